// ===== hw/rtl/bitplane_pixel_decoder_top_macros.svh =====
// Assertion helpers for the checker file of the decoder.
`ifndef BITPLANE_PIXEL_DECODER_TOP_MACROS_SVH
`define BITPLANE_PIXEL_DECODER_TOP_MACROS_SVH

// Plain property, sampled on the rising clock edge, switched off during reset.
`define BPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication with the antecedent and the consequent given apart.
`define BPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bpd_pkg.sv =====
package bpd_pkg;

  localparam int unsigned PIXELS_PER_GROUP = 16;
  localparam int unsigned PALETTE_ENTRIES  = 16;
  localparam int unsigned PIX_CNT_W        = $clog2(PIXELS_PER_GROUP);
  localparam int unsigned IDX_W            = $clog2(PALETTE_ENTRIES);
  localparam int unsigned PLANE_W          = 16;
  localparam int unsigned NUM_PLANES       = 4;
  localparam int unsigned PAL_W            = 12;
  localparam int unsigned IN_TDATA_W       = 80;
  localparam int unsigned OUT_TDATA_W      = 32;

  // Display modes; both upper codes mean monochrome.
  localparam logic [1:0] MODE_FOUR_PLANES = 2'd0;
  localparam logic [1:0] MODE_TWO_PLANES  = 2'd1;

  // Item kinds carried on the input tuser.
  localparam logic OP_DECODE    = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  localparam logic [23:0] MONO_WHITE_RGB = 24'hFF_FFFF;
  localparam logic [23:0] MONO_BLACK_RGB = 24'h00_0000;

  // One beat leaving the serialiser.
  typedef struct packed {
    logic             is_write;
    logic             last;
    logic             mono;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] entry_index;
    logic [PAL_W-1:0] entry_word;
  } bpd_beat_t;

  // One pixel after the palette look-up.
  typedef struct packed {
    logic             last;
    logic             mono;
    logic [IDX_W-1:0] index;
    logic [PAL_W-1:0] word;
  } bpd_colour_t;

  // The top bit of a gun field is the gun's LSB; widen by nibble replication.
  function automatic logic [7:0] gun_expand(input logic [3:0] field);
    logic [3:0] g4;
    g4 = {field[2:0], field[3]};
    return {g4, g4};
  endfunction

endpackage

// ===== hw/rtl/bpd_serializer.sv =====
module bpd_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    mode_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_op_i,
  input  logic [bpd_pkg::IN_TDATA_W-1:0] in_data_i,
  output logic                          beat_valid_o,
  input  logic                          beat_ready_i,
  output bpd_pkg::bpd_beat_t            beat_o
);
  import bpd_pkg::*;

  logic                   busy_q;
  logic [PIX_CNT_W-1:0]   cnt_q;
  logic                   is_write_q;
  logic [PLANE_W-1:0]     plane_q [NUM_PLANES];
  logic [IDX_W-1:0]       entry_index_q;
  logic [PAL_W-1:0]       entry_word_q;
  logic                   beat_last;
  logic                   take;
  logic                   accept;
  logic [IDX_W-1:0]       index;

  // The leftmost remaining pixel always sits in bit 15 of each plane register.
  always_comb begin
    case (mode_i)
      MODE_FOUR_PLANES: index = {plane_q[3][PLANE_W-1], plane_q[2][PLANE_W-1],
                                 plane_q[1][PLANE_W-1], plane_q[0][PLANE_W-1]};
      MODE_TWO_PLANES:  index = {2'b00, plane_q[1][PLANE_W-1], plane_q[0][PLANE_W-1]};
      default:          index = {3'b000, plane_q[0][PLANE_W-1]};
    endcase
  end

  assign beat_last    = is_write_q || (cnt_q == PIX_CNT_W'(PIXELS_PER_GROUP - 1));
  assign take         = busy_q && beat_ready_i;
  assign in_ready_o   = !busy_q || (beat_ready_i && beat_last);
  assign accept       = in_valid_i && in_ready_o;
  assign beat_valid_o = busy_q;

  assign beat_o.is_write    = is_write_q;
  assign beat_o.last        = beat_last;
  assign beat_o.mono        = mode_i[1];
  assign beat_o.index       = index;
  assign beat_o.entry_index = entry_index_q;
  assign beat_o.entry_word  = entry_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (take && beat_last) begin
      busy_q <= 1'b0;
    end else if (take) begin
      cnt_q <= cnt_q + PIX_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_write_q    <= (in_op_i == OP_PAL_WRITE);
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_q[p] <= in_data_i[p*PLANE_W +: PLANE_W];
      end
      entry_index_q <= in_data_i[NUM_PLANES*PLANE_W +: IDX_W];
      entry_word_q  <= in_data_i[NUM_PLANES*PLANE_W + IDX_W +: PAL_W];
    end else if (take) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_q[p] <= {plane_q[p][PLANE_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/bpd_palette.sv =====
module bpd_palette (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_valid_i,
  output logic                 beat_ready_o,
  input  bpd_pkg::bpd_beat_t   beat_i,
  output logic                 pix_valid_o,
  input  logic                 pix_ready_i,
  output bpd_pkg::bpd_colour_t pix_o
);
  import bpd_pkg::*;

  logic [PAL_W-1:0] pal_q [PALETTE_ENTRIES];
  logic             valid_q;
  bpd_colour_t      pix_q;
  logic             load;

  assign beat_ready_o = !valid_q || pix_ready_i;
  assign load         = beat_valid_i && beat_ready_o;
  assign pix_valid_o  = valid_q;
  assign pix_o        = pix_q;

  // Palette writes travel in order with the pixels, so earlier pixels still see
  // the old entry and later ones the new.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < PALETTE_ENTRIES; e++) begin
        pal_q[e] <= '0;
      end
    end else if (load && beat_i.is_write) begin
      pal_q[beat_i.entry_index] <= beat_i.entry_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (beat_ready_o) begin
      valid_q <= beat_valid_i && !beat_i.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q.last  <= beat_i.last;
      pix_q.mono  <= beat_i.mono;
      pix_q.index <= beat_i.index;
      pix_q.word  <= pal_q[beat_i.index];
    end
  end

endmodule

// ===== hw/rtl/bpd_expand.sv =====
module bpd_expand (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pix_valid_i,
  output logic                            pix_ready_o,
  input  bpd_pkg::bpd_colour_t            pix_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bpd_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                            out_last_o
);
  import bpd_pkg::*;

  logic                   valid_q;
  logic [OUT_TDATA_W-1:0] data_q;
  logic                   last_q;
  logic [23:0]            rgb;
  logic                   load;

  always_comb begin
    if (pix_i.mono) begin
      rgb = (pix_i.index == '0) ? MONO_WHITE_RGB : MONO_BLACK_RGB;
    end else begin
      rgb = {gun_expand(pix_i.word[3:0]), gun_expand(pix_i.word[7:4]),
             gun_expand(pix_i.word[11:8])};
    end
  end

  assign pix_ready_o = !valid_q || out_ready_i;
  assign load        = pix_valid_i && pix_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pix_ready_o) begin
      valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= {4'b0000, pix_i.index, rgb};
      last_q <= pix_i.last;
    end
  end

endmodule

// ===== hw/rtl/bitplane_pixel_decoder_top.sv =====
// Bitplane pixel decoder: a decode beat on the slave side carries four plane
// words for sixteen pixels and yields sixteen master beats, leftmost pixel
// first, the last one with tlast set; a palette-write beat updates one entry
// and yields nothing. The input serialiser hands on a decode group one pixel
// per cycle while the palette stage accepts its beats, and a palette write as
// one beat; the next item is taken in the cycle the previous one's final pixel
// leaves the serialiser. From the serialiser a pixel passes the palette register
// stage and the colour expansion stage before it is offered on the master side.
// The mode register is read live and is meant to be written only while no group
// is in flight.
module bitplane_pixel_decoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_data_i,     // display_mode
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // plane_word_0, plane_word_1, plane_word_2, plane_word_3, entry_index, entry_word
  input  logic [bpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,   // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // red, green, blue, color_index, four zero bits
  output logic [bpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast    // last_pixel
);
  import bpd_pkg::*;

  logic        [1:0] mode_q;
  logic              beat_valid;
  logic              beat_ready;
  bpd_beat_t         beat;
  logic              pix_valid;
  logic              pix_ready;
  bpd_colour_t       pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FOUR_PLANES;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  bpd_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .beat_valid_o (beat_valid),
    .beat_ready_i (beat_ready),
    .beat_o       (beat)
  );

  bpd_palette u_pal (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_ready_o (beat_ready),
    .beat_i       (beat),
    .pix_valid_o  (pix_valid),
    .pix_ready_i  (pix_ready),
    .pix_o        (pix)
  );

  bpd_expand u_exp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_ready_o (pix_ready),
    .pix_i       (pix),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/bpd_checker.sv =====
`include "bitplane_pixel_decoder_top_macros.svh"

module bpd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [1:0]                      cfg_data_i,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import bpd_pkg::*;

  // Monochrome flag of the mode as last written through the port.
  logic mono_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mono_q <= cfg_data_i[1];
    end
  end

  `BPD_ASSERT_IMPL(a_out_hold, m_axis_tvalid && !m_axis_tready,
    ##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)),
    "stalled output beat changed")
  `BPD_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[31:28] == 4'b0000,
    "padding bits of output beat not zero")
  `BPD_ASSERT_IMPL(a_nibble_rep, m_axis_tvalid && !mono_q,
    (m_axis_tdata[7:4] == m_axis_tdata[3:0]) && (m_axis_tdata[15:12] == m_axis_tdata[11:8])
    && (m_axis_tdata[23:20] == m_axis_tdata[19:16]),
    "colour gun not nibble replicated")
  `BPD_ASSERT_IMPL(a_mono_colour, m_axis_tvalid && mono_q,
    ((m_axis_tdata[27:24] == 4'd0) && (m_axis_tdata[23:0] == MONO_WHITE_RGB))
    || ((m_axis_tdata[27:24] == 4'd1) && (m_axis_tdata[23:0] == MONO_BLACK_RGB)),
    "monochrome pixel has wrong index or colour")

endmodule

bind bitplane_pixel_decoder_top bpd_checker u_bpd_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bpd_pkg::*;

  // Both upper mode codes select the single-plane monochrome display.
  localparam logic [1:0] MODE_MONO     = 2'd2;
  localparam logic [1:0] MODE_MONO_ALT = 2'd3;

  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned TAIL_CYCLES      = 40;
  localparam int unsigned LONG_HOLD_AFTER  = 50;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned RANDOM_PHASES    = 5;

  typedef enum logic [0:0] {ROW_CFG, ROW_ITEM} row_kind_e;

  // One directed row: planes are {plane_word_3, plane_word_2, plane_word_1, plane_word_0}.
  // Where typed is set, every pixel of the group is expected to carry rgb and idx.
  typedef struct packed {
    row_kind_e   kind;
    logic        op;
    logic [1:0]  mode;
    logic [63:0] planes;
    logic [3:0]  eidx;
    logic [11:0] eword;
    logic        typed;
    logic [23:0] rgb;
    logic [3:0]  idx;
  } row_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] idx;
    logic       last;
  } pixel_t;

  localparam int unsigned DIRECTED_ROWS = 24;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h0, 4'h0, 12'h000, 1'b1, 24'h000000, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'h0, 12'h000, 1'b1, 24'h000000,
      4'hF},
    '{ROW_ITEM, OP_PAL_WRITE, 2'd0, 64'h0, 4'hF, 12'hFFF, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'h0, 12'h000, 1'b1, 24'hFFFFFF,
      4'hF},
    '{ROW_ITEM, OP_PAL_WRITE, 2'd0, 64'h0, 4'h0, 12'h888, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h0, 4'hF, 12'hFFF, 1'b1, 24'h111111, 4'h0},
    '{ROW_ITEM, OP_PAL_WRITE, 2'd0, 64'hDEAD_BEEF_0123_4567, 4'h3, 12'h777, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h0000_0000_FFFF_FFFF, 4'h0, 12'h000, 1'b1, 24'hEEEEEE,
      4'h3},
    '{ROW_ITEM, OP_PAL_WRITE, 2'd0, 64'h0, 4'h9, 12'h5A3, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_PAL_WRITE, 2'd0, 64'h0, 4'h6, 12'h0C1, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'hFF00_F0F0_CCCC_AAAA, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h0000_FFFF_0000_FFFF, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_CFG,  OP_DECODE,    MODE_TWO_PLANES, 64'h0, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'hFFFF_FFFF_0000_FFFF, 4'h0, 12'h000, 1'b1, 24'h000000,
      4'h1},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h1234_5678_AAAA_5555, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_CFG,  OP_DECODE,    MODE_MONO, 64'h0, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'hFFFF_FFFF_FFFF_0000, 4'h0, 12'h000, 1'b1, 24'hFFFFFF,
      4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h0000_0000_0000_FFFF, 4'h0, 12'h000, 1'b1, 24'h000000,
      4'h1},
    '{ROW_ITEM, OP_PAL_WRITE, 2'd0, 64'h0, 4'h1, 12'hABC, 1'b0, 24'h0, 4'h0},
    '{ROW_CFG,  OP_DECODE,    MODE_MONO_ALT, 64'h0, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h5A5A_A5A5_3C3C_5A5A, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_CFG,  OP_DECODE,    MODE_FOUR_PLANES, 64'h0, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'h0000_0000_0000_FFFF, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0},
    '{ROW_ITEM, OP_DECODE,    2'd0, 64'hF0F0_0FF0_3C3C_9696, 4'h0, 12'h000, 1'b0, 24'h0, 4'h0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  logic [11:0]  pal_words [PALETTE_ENTRIES];
  logic [1:0]   mode_now;
  pixel_t       pixel_q [$];
  int unsigned  accepted_items;
  int unsigned  burst_left;
  int unsigned  mismatches;

  bitplane_pixel_decoder_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // The top bit of a gun field is the gun's LSB; the nibble is then repeated.
  function automatic logic [7:0] widen_gun(input logic [3:0] f);
    return {f[2:0], f[3], f[2:0], f[3]};
  endfunction

  function automatic pixel_t predict_pixel(input logic [63:0] planes, input int unsigned k);
    int unsigned bitpos;
    logic [11:0] w;
    pixel_t      px;
    bitpos = 15 - k;
    px.idx = '0;
    px.idx[0] = planes[bitpos];
    if (mode_now == MODE_FOUR_PLANES || mode_now == MODE_TWO_PLANES) begin
      px.idx[1] = planes[16 + bitpos];
    end
    if (mode_now == MODE_FOUR_PLANES) begin
      px.idx[2] = planes[32 + bitpos];
      px.idx[3] = planes[48 + bitpos];
    end
    if (mode_now == MODE_MONO || mode_now == MODE_MONO_ALT) begin
      {px.red, px.green, px.blue} = (px.idx == 4'h0) ? 24'hFFFFFF : 24'h000000;
    end else begin
      w = pal_words[px.idx];
      px.red   = widen_gun(w[11:8]);
      px.green = widen_gun(w[7:4]);
      px.blue  = widen_gun(w[3:0]);
    end
    px.last = (k == PIXELS_PER_GROUP - 1);
    return px;
  endfunction

  function automatic logic [15:0] some_plane_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input logic op, input logic [63:0] planes, input logic [3:0] eidx,
                           input logic [11:0] eword, input logic typed,
                           input logic [23:0] rgb, input logic [3:0] idx);
    int unsigned gap;
    pixel_t      px;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {eword, eidx, planes};
    do @(posedge clk_i); while (!s_axis_tready);
    accepted_items++;
    if (op == OP_PAL_WRITE) begin
      pal_words[eidx] = eword;
    end else begin
      for (int unsigned k = 0; k < PIXELS_PER_GROUP; k++) begin
        px = predict_pixel(planes, k);
        if (typed) begin
          {px.red, px.green, px.blue} = rgb;
          px.idx = idx;
        end
        pixel_q.push_back(px);
      end
    end
  endtask

  // The mode is read live, so a write waits until every pixel has left and any
  // trailing palette write has had time to pass through.
  task automatic set_mode(input logic [1:0] mode);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    mode_now = mode;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        $error("pixel beat with nothing outstanding: tdata=%h tlast=%b", m_axis_tdata,
               m_axis_tlast);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        check_field("red", want.red, m_axis_tdata[7:0]);
        check_field("green", want.green, m_axis_tdata[15:8]);
        check_field("blue", want.blue, m_axis_tdata[23:16]);
        check_field("color_index", 8'(want.idx), 8'(m_axis_tdata[27:24]));
        check_field("last_pixel", 8'(want.last), 8'(m_axis_tlast));
      end
    end
  end

  initial begin : receiver
    int unsigned span;
    int unsigned style;
    bit          held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      // Once, well into the run, hold off long enough for the block to back up.
      if (!held && accepted_items >= LONG_HOLD_AFTER) begin
        held = 1'b1;
        repeat (LONG_HOLD_CYCLES) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
        end
      end
      style = $urandom_range(0, 3);
      span  = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk_i);
        case (style)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = ($urandom_range(0, 3) != 0);
          2:       m_axis_tready = ($urandom_range(0, 3) == 0);
          default: m_axis_tready = ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    row_t        row;
    int unsigned count;
    logic        op;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_DECODE;
    mode_now       = MODE_FOUR_PLANES;
    accepted_items = 0;
    burst_left     = 0;
    mismatches     = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) pal_words[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_CFG) begin
        set_mode(row.mode);
      end else begin
        send_item(row.op, row.planes, row.eidx, row.eword, row.typed, row.rgb, row.idx);
      end
    end

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase != 0) set_mode(2'($urandom_range(0, 3)));
      count = $urandom_range(60, 80);
      repeat (count) begin
        op = ($urandom_range(0, 9) < 3) ? OP_PAL_WRITE : OP_DECODE;
        send_item(op, {some_plane_word(), some_plane_word(), some_plane_word(),
                       some_plane_word()},
                  4'($urandom()), 12'($urandom()), 1'b0, 24'h0, 4'h0);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== bitplane_pixel_decoder_top.f =====
+incdir+hw/rtl
hw/rtl/bpd_pkg.sv
hw/rtl/bpd_serializer.sv
hw/rtl/bpd_palette.sv
hw/rtl/bpd_expand.sv
hw/rtl/bitplane_pixel_decoder_top.sv
hw/rtl/bpd_checker.sv
verif/tb_top.sv
